// ===== rtl/orb_pkg.sv =====
package orb_pkg;

  localparam int ORB_DEPTH  = 64;
  localparam int ORB_WORD_W = 64;
  localparam int ORB_CAP_W  = 7;
  localparam int ORB_POS_W  = 6;
  localparam int ORB_ACT_W  = 3;

  localparam int ORB_IN_TDATA_W  = 80;
  localparam int ORB_OUT_TDATA_W = 80;

  typedef enum logic [ORB_ACT_W-1:0] {
    ACT_ENQUEUE   = 3'd0,
    ACT_READ_POS  = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_PEEK_HEAD = 3'd3,
    ACT_PEEK_TAIL = 3'd4
  } action_t;

endpackage

// ===== rtl/overwriting_ring_buffer_top.sv =====
// Overwriting ring buffer of signed 64-bit words. Each input transfer carries one action
// (enqueue, read at an offset from the oldest entry, clear, peek oldest, peek newest) and
// yields exactly one result transfer with the word read, an ok flag, the entry count and a
// full flag. The store is a single-port synchronous RAM, so the read data and the item's status
// are first held in a pending stage and then registered into the output slot; the next item is
// taken in the cycle that result is transferred, so a new item is never taken before the last
// result has gone. Because only one item is in flight, a read never overlaps a write to the same
// entry. Writing the capacity register clamps it to 1..DEPTH and clears the ring; it must be
// written only while the block is idle.
module overwriting_ring_buffer_top
  import orb_pkg::*;
#(
  parameter int DEPTH = ORB_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input item: action[2:0], word_in[66:3], position[72:67], zero padded.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ORB_IN_TDATA_W-1:0]  in_tdata,
  // Result item: word_out[63:0], ok[64], count[71:65], full_res[72], zero padded.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ORB_OUT_TDATA_W-1:0] out_tdata,
  input  logic                       cfg_we,
  input  logic [ORB_CAP_W-1:0]       cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = AW + 8;
  localparam logic [ORB_CAP_W-1:0] CAP_RST =
    (DEPTH < 64) ? ORB_CAP_W'(DEPTH) : ORB_CAP_W'(64);

  logic [ORB_CAP_W-1:0]  cap_r, cap_nxt;
  logic [AW-1:0]         oldest_r, oldest_nxt;
  logic [AW-1:0]         newest_r, newest_nxt;
  logic [ORB_CAP_W-1:0]  count_r, count_nxt;

  logic                  pend_r, pend_nxt;
  logic                  pend_ram_r, pend_ram_nxt;
  logic                  pend_ok_r, pend_ok_nxt;
  logic [ORB_CAP_W-1:0]  pend_count_r, pend_count_nxt;
  logic                  pend_full_r, pend_full_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ORB_WORD_W-1:0] out_word_r, out_word_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [ORB_CAP_W-1:0]  out_count_r, out_count_nxt;
  logic                  out_full_r, out_full_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [ORB_WORD_W-1:0] ram_rdata;

  logic                  in_fire;
  action_t               in_action;
  logic [ORB_WORD_W-1:0] in_word;
  logic [ORB_POS_W-1:0]  in_pos;

  logic [ORB_CAP_W-1:0]  cfg_cap;
  logic [AW-1:0]         enq_newest;
  logic [SW-1:0]         pos_sum;
  logic [SW-1:0]         pos_idx;
  logic                  is_empty;
  logic                  is_full;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx,
                                             input logic [ORB_CAP_W-1:0] cap);
    logic [SW-1:0] inc;
    inc = SW'(idx) + SW'(1);
    return (inc >= SW'(cap)) ? '0 : AW'(inc);
  endfunction

  assign in_action = action_t'(in_tdata[2:0]);
  assign in_word   = in_tdata[66:3];
  assign in_pos    = in_tdata[72:67];

  // Only one item in flight: the next is taken once the output slot is free.
  assign in_tready = !pend_r && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == cap_r);

  always_comb begin
    cfg_cap = cfg_wdata;
    if (cfg_cap == '0) begin
      cfg_cap = ORB_CAP_W'(1);
    end
    if ((SW'(cfg_cap)) > SW'(DEPTH)) begin
      cfg_cap = ORB_CAP_W'(DEPTH);
    end
  end

  assign enq_newest = is_empty ? newest_r : wrap_next(newest_r, cap_r);

  // The oldest pointer is nonzero only while the ring is full, so the sum stays below
  // twice the count and one subtraction replaces the modulo.
  assign pos_sum = SW'(oldest_r) + SW'(in_pos);
  assign pos_idx = (pos_sum >= SW'(count_r)) ? (pos_sum - SW'(count_r)) : pos_sum;

  always_comb begin
    cap_nxt      = cap_r;
    oldest_nxt   = oldest_r;
    newest_nxt   = newest_r;
    count_nxt    = count_r;
    ram_we       = 1'b0;
    ram_addr     = oldest_r;
    pend_ram_nxt = pend_ram_r;
    pend_ok_nxt  = pend_ok_r;
    if (cfg_we) begin
      cap_nxt    = cfg_cap;
      oldest_nxt = '0;
      newest_nxt = '0;
      count_nxt  = '0;
    end else if (in_fire) begin
      pend_ram_nxt = 1'b0;
      pend_ok_nxt  = 1'b1;
      case (in_action)
        ACT_ENQUEUE: begin
          ram_we     = 1'b1;
          ram_addr   = enq_newest;
          newest_nxt = enq_newest;
          if (is_full) begin
            oldest_nxt = wrap_next(enq_newest, cap_r);
          end else begin
            count_nxt = count_r + ORB_CAP_W'(1);
          end
        end
        ACT_READ_POS: begin
          if (ORB_CAP_W'(in_pos) < count_r) begin
            ram_addr     = AW'(pos_idx);
            pend_ram_nxt = 1'b1;
          end else begin
            pend_ok_nxt = 1'b0;
          end
        end
        ACT_CLEAR: begin
          oldest_nxt = '0;
          newest_nxt = '0;
          count_nxt  = '0;
        end
        ACT_PEEK_HEAD: begin
          ram_addr     = oldest_r;
          pend_ram_nxt = !is_empty;
        end
        ACT_PEEK_TAIL: begin
          ram_addr     = newest_r;
          pend_ram_nxt = !is_empty;
        end
        default: begin
        end
      endcase
    end
  end

  assign pend_nxt       = in_fire;
  assign pend_count_nxt = in_fire ? count_nxt : pend_count_r;
  assign pend_full_nxt  = in_fire ? (count_nxt == cap_r) : pend_full_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_ok_nxt    = out_ok_r;
    out_count_nxt = out_count_r;
    out_full_nxt  = out_full_r;
    if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = pend_ram_r ? ram_rdata : '0;
      out_ok_nxt    = pend_ok_r;
      out_count_nxt = pend_count_r;
      out_full_nxt  = pend_full_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  orb_ram #(
    .WIDTH(ORB_WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_word),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RST;
      oldest_r    <= '0;
      newest_r    <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_ram_r   <= pend_ram_nxt;
    pend_ok_r    <= pend_ok_nxt;
    pend_count_r <= pend_count_nxt;
    pend_full_r  <= pend_full_nxt;
    out_word_r   <= out_word_nxt;
    out_ok_r     <= out_ok_nxt;
    out_count_r  <= out_count_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_full_r, out_count_r, out_ok_r, out_word_r};

`ifndef ASSERT_OFF
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count exceeds capacity");

  a_oldest_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_r != '0) |-> (count_r == cap_r))
    else $error("oldest pointer moved while ring not full");

  a_pend_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !out_valid_r)
    else $error("read data arrives while output slot is occupied");

  a_bad_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_word_r == '0))
    else $error("failed positional read returned nonzero word");
`endif

endmodule

// ===== rtl/orb_ram.sv =====
module orb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== verif/overwriting_ring_buffer_top_test.sv =====
module overwriting_ring_buffer_top_test;
  import orb_pkg::*;

  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
  localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] WORD_MAX = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] word;
    logic        ok;
    logic [6:0]  count;
    logic        full;
  } ring_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  // Input item: action[2:0], word_in[66:3], position[72:67], zero padded.
  logic [ORB_IN_TDATA_W-1:0]  in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  // Result item: word_out[63:0], ok[64], count[71:65], full_res[72], zero padded.
  logic [ORB_OUT_TDATA_W-1:0] out_tdata;
  logic                       cfg_we = 1'b0;
  logic [ORB_CAP_W-1:0]       cfg_wdata = '0;

  overwriting_ring_buffer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the ring.
  logic [63:0] ring_words [ORB_DEPTH];
  int unsigned oldest_ix;
  int unsigned newest_ix;
  int unsigned stored_n;
  int unsigned cap_eff;

  ring_result_t pending_results [$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  burst_left = 0;

  function automatic int unsigned ring_next(input int unsigned ix);
    return (ix + 1 >= cap_eff) ? 0 : ix + 1;
  endfunction

  function automatic ring_result_t ring_apply(input logic [2:0] act, input logic [63:0] w,
                                              input logic [5:0] pos);
    ring_result_t r;
    r.word = '0;
    r.ok   = 1'b1;
    case (act)
      ACT_ENQUEUE: begin
        if (stored_n != 0) newest_ix = ring_next(newest_ix);
        ring_words[newest_ix] = w;
        if (stored_n == cap_eff) oldest_ix = ring_next(newest_ix);
        else stored_n++;
      end
      ACT_READ_POS: begin
        if (pos < stored_n) r.word = ring_words[(oldest_ix + pos) % stored_n];
        else r.ok = 1'b0;
      end
      ACT_CLEAR: begin
        oldest_ix = 0;
        newest_ix = 0;
        stored_n  = 0;
      end
      ACT_PEEK_HEAD: if (stored_n != 0) r.word = ring_words[oldest_ix];
      ACT_PEEK_TAIL: if (stored_n != 0) r.word = ring_words[newest_ix];
      default: ;
    endcase
    r.count = stored_n[6:0];
    r.full  = (stored_n == cap_eff);
    return r;
  endfunction

  task automatic check_result(input logic [ORB_OUT_TDATA_W-1:0] data);
    ring_result_t want;
    ring_result_t got;
    got.word  = data[63:0];
    got.ok    = data[64];
    got.count = data[71:65];
    got.full  = data[72];
    if (pending_results.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("unexpected result transfer: word=%h ok=%b count=%0d full=%b",
                 got.word, got.ok, got.count, got.full);
    end else begin
      want = pending_results.pop_front();
      if (got.word !== want.word || got.ok !== want.ok || got.count !== want.count ||
          got.full !== want.full) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display({"result mismatch: expected word=%h ok=%b count=%0d full=%b, ",
                    "got word=%h ok=%b count=%0d full=%b"},
                   want.word, want.ok, want.count, want.full,
                   got.word, got.ok, got.count, got.full);
      end
    end
  endtask

  // Receiver: checks every result transfer and switches between stall modes.
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      rx_tick <= rx_tick + 1;
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(3, 0);
        rx_mode_left <= $urandom_range(200, 20);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(1, 0));
        2: out_tready <= (rx_tick % 4 == 0);
        default: begin
          if (rx_stall_left != 0) begin
            out_tready    <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
          end else begin
            out_tready <= 1'b1;
            if ($urandom_range(3, 0) == 0) rx_stall_left <= $urandom_range(12, 1);
          end
        end
      endcase
    end
  end

  // Sends one item and records its expected result once the transfer happens.
  task automatic issue_action(input logic [2:0] act, input logic [63:0] w,
                              input logic [5:0] pos);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, pos, w, act};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(ring_apply(act, w, pos));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 0);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [ORB_CAP_W-1:0] v);
    in_tvalid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v == 0) cap_eff = 1;
    else if (v > ORB_DEPTH) cap_eff = ORB_DEPTH;
    else cap_eff = 32'(v);
    oldest_ix = 0;
    newest_ix = 0;
    stored_n  = 0;
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(31, 0))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_empty_ring();
    issue_action(ACT_PEEK_HEAD, pick_word(), 6'd0);
    issue_action(ACT_PEEK_TAIL, pick_word(), 6'd63);
    issue_action(ACT_READ_POS, '0, 6'd0);
    issue_action(ACT_UNUSED_LAST, WORD_MAX, 6'd63);
  endtask

  task automatic test_word_extremes();
    issue_action(ACT_ENQUEUE, WORD_MIN, 6'd0);
    issue_action(ACT_ENQUEUE, WORD_MAX, 6'd0);
    issue_action(ACT_ENQUEUE, '0, 6'd63);
    issue_action(ACT_READ_POS, '1, 6'd0);
    issue_action(ACT_READ_POS, '0, 6'd2);
    issue_action(ACT_READ_POS, '0, 6'd3);
    issue_action(ACT_PEEK_HEAD, '0, 6'd0);
    issue_action(ACT_PEEK_TAIL, '0, 6'd0);
    issue_action(ACT_CLEAR, '1, 6'd63);
    issue_action(ACT_PEEK_TAIL, '0, 6'd0);
  endtask

  // Five enqueues into three entries force the oldest to be overwritten twice.
  task automatic test_small_capacity_wrap();
    set_capacity(7'd3);
    repeat (5) issue_action(ACT_ENQUEUE, pick_word(), 6'($urandom_range(63, 0)));
    issue_action(ACT_READ_POS, '0, 6'd0);
    issue_action(ACT_READ_POS, '0, 6'd2);
    issue_action(ACT_READ_POS, '0, 6'd3);
    issue_action(ACT_PEEK_HEAD, '0, 6'd0);
  endtask

  // A capacity of zero behaves as a single entry.
  task automatic test_capacity_clamp();
    set_capacity(7'd0);
    issue_action(ACT_ENQUEUE, pick_word(), 6'd0);
    issue_action(ACT_ENQUEUE, pick_word(), 6'd0);
    issue_action(ACT_READ_POS, '0, 6'd0);
  endtask

  task automatic test_random_mix(input logic [ORB_CAP_W-1:0] cap, input int unsigned n_items,
                                 input int unsigned enq_pct, input int unsigned clear_pct);
    int unsigned done_n;
    int unsigned r;
    logic [2:0]  act;
    logic [5:0]  pos;
    done_n = 0;
    set_capacity(cap);
    while (done_n < n_items) begin
      r   = $urandom_range(99, 0);
      pos = 6'($urandom_range(63, 0));
      if (r < enq_pct) act = ACT_ENQUEUE;
      else if (r < enq_pct + clear_pct) act = ACT_CLEAR;
      else if (r < enq_pct + clear_pct + 4)
        act = 3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
      else begin
        case ($urandom_range(4, 0))
          0: act = ACT_PEEK_HEAD;
          1: act = ACT_PEEK_TAIL;
          default: begin
            act = ACT_READ_POS;
            if (stored_n != 0 && $urandom_range(4, 0) != 0)
              pos = 6'($urandom_range(stored_n - 1, 0));
          end
        endcase
      end
      issue_action(act, pick_word(), pos);
      if (act < ACT_UNUSED_FIRST) done_n++;
    end
  endtask

  initial begin
    cap_eff   = ORB_DEPTH;
    oldest_ix = 0;
    newest_ix = 0;
    stored_n  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ring();
    test_word_extremes();
    test_small_capacity_wrap();
    test_capacity_clamp();
    test_random_mix(7'd1, 80, 40, 4);
    test_random_mix(7'd127, 220, 65, 1);
    test_random_mix(7'($urandom_range(63, 2)), 150, 45, 3);
    test_random_mix(7'd64, 150, 45, 2);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
